// ===== design/lru_cache_miss_counter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// LRU miss counter assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_MISS_COUNTER_UNIT_MACROS_SVH
`define LRU_CACHE_MISS_COUNTER_UNIT_MACROS_SVH

// same-cycle implication
`define LRUCMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRUCMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lrucmc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU miss counter package
// Shared widths, defaults and the per-cell command type.
// ----------------------------------------------------------------------------
package lrucmc_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam int PAGE_W = 16;  // request identifier field
  localparam int CAP_W  = 5;   // capacity register
  localparam int CNT_W  = 32;  // miss total

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic shift;  // take the entry of the next-newer neighbor
    logic load;   // take the requested identifier
  } lrucmc_cell_cmd_t;

endpackage

// ===== design/lrucmc_if.sv =====
// ----------------------------------------------------------------------------
// LRU miss counter channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface lrucmc_req_if
  import lrucmc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_id;

  modport source (output valid, output page_id, input ready);
  modport sink   (input valid, input page_id, output ready);
endinterface

interface lrucmc_rsp_if
  import lrucmc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [CNT_W-1:0] miss_total;

  modport source (output valid, output hit, output miss_total, input ready);
  modport sink   (input valid, input hit, input miss_total, output ready);
endinterface

// ===== design/lru_cache_miss_counter_unit.sv =====
// ----------------------------------------------------------------------------
// LRU cache miss counter
// Fully associative LRU directory of page identifiers with a miss total.
// ----------------------------------------------------------------------------
// A request carries one page identifier; each yields one response with the
// hit flag and the saturating miss count after that request. The directory is
// a row of cells ordered oldest (cell 0) to newest; all cells compare at once.
// Requests run at one per cycle while the output register is free or draining: a hit,
// a miss with room, and a miss on a full directory (oldest entry dropped while the row
// shifts) each pass the lookup stage unstalled. Only after capacity is lowered below
// the current fill does a miss cost more: one trim step per surplus entry, each step
// shifting the row by one cell. A response waits in an output register, so the next
// request is taken while it is held; capacity writes belong to idle periods.
// ----------------------------------------------------------------------------
`include "lru_cache_miss_counter_unit_macros.svh"

module lru_cache_miss_counter_unit
  import lrucmc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  lrucmc_req_if.sink       req,
  lrucmc_rsp_if.source     rsp
);

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_ENTRIES);

  logic [CAP_W-1:0]   capacity;
  logic [OCC_W-1:0]   occupancy;
  logic [CNT_W-1:0]   miss_counter;
  logic [CNT_W-1:0]   miss_counter_next;
  logic               req_valid;
  logic [ID_BITS-1:0] req_id;
  logic               out_valid;
  logic               out_hit;
  logic [CNT_W-1:0]   out_total;

  logic [CW-1:0] cap_eff;
  logic [CW-1:0] n;
  logic [CW-1:0] n_m1;
  logic          slot_free;
  logic          hit_any;
  logic          grow;
  logic          trim;
  logic          done;
  logic          move;

  logic [ID_BITS-1:0]     entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] vmatch;
  logic [MAX_ENTRIES-1:0] seen;
  lrucmc_cell_cmd_t       cmd [MAX_ENTRIES];

  // capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    cap_eff = CW'(capacity);
    if (cap_eff == '0) begin
      cap_eff = CW'(1);
    end else if (cap_eff > MAX_CW) begin
      cap_eff = MAX_CW;
    end
  end

  assign n         = CW'(occupancy);
  assign n_m1      = n - CW'(1);
  assign slot_free = !out_valid || rsp.ready;
  assign hit_any   = |vmatch;
  assign grow      = req_valid && !hit_any && (n < cap_eff);
  assign trim      = req_valid && !hit_any && (n > cap_eff);
  assign done      = req_valid && slot_free && !trim;
  // row shifts below the newest slot: on a hit from the match upward
  assign move      = (done && !grow) || trim;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ID_BITS-1:0] newer;

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign newer = '0;
    end else begin : g_mid
      assign newer = entry[i+1];
    end

    assign seen[i] = |vmatch[i:0];

    assign vmatch[i] = match[i] && (CW'(i) < n);

    always_comb begin
      cmd[i].shift = move && (CW'(i) < n_m1) && (seen[i] || !hit_any);
      cmd[i].load  = done && ((grow && (CW'(i) == n)) || (!grow && (CW'(i) == n_m1)));
    end

    lrucmc_cell #(
      .ID_W (ID_BITS)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd[i]),
      .newer (newer),
      .id    (req_id),
      .entry (entry[i]),
      .match (match[i])
    );
  end

  assign miss_counter_next = (miss_counter == '1) ? miss_counter : miss_counter + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      occupancy    <= '0;
      miss_counter <= '0;
      req_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (trim) begin
        occupancy <= OCC_W'(n_m1);
      end else if (done && grow) begin
        occupancy <= occupancy + OCC_W'(1);
      end
      if (done && !hit_any) begin
        miss_counter <= miss_counter_next;
      end
      if (req.valid && req.ready) begin
        req_valid <= 1'b1;
      end else if (done) begin
        req_valid <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_id <= ID_BITS'(req.page_id);
    end
    if (done) begin
      out_hit   <= hit_any;
      out_total <= hit_any ? miss_counter : miss_counter_next;
    end
  end

  assign req.ready      = !req_valid || done;
  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.miss_total = out_total;

  `LRUCMC_ASSERT_NOW(a_unique_match, 1'b1, $onehot0(vmatch), "duplicate identifier in directory")
  `LRUCMC_ASSERT_NOW(a_stall_holds, req_valid && !done, !req.ready, "request taken while one is pending")
  `LRUCMC_ASSERT_NEXT(a_hit_keeps_fill, done && hit_any, occupancy == $past(occupancy), "hit changed occupancy")
  `LRUCMC_ASSERT_NEXT(a_trim_drops_one, trim, occupancy == $past(occupancy) - OCC_W'(1), "trim step did not drop one entry")
  `LRUCMC_ASSERT_NEXT(a_miss_counts, done && !hit_any && miss_counter != '1, miss_counter == $past(miss_counter) + CNT_W'(1), "miss not counted")

endmodule

// ===== design/lrucmc_cell.sv =====
// ----------------------------------------------------------------------------
// LRU directory cell
// One recency slot: holds an identifier, compares it, shifts or loads.
// ----------------------------------------------------------------------------
module lrucmc_cell
  import lrucmc_pkg::*;
#(
  parameter int ID_W = ID_BITS_DEF
) (
  input  logic             clk,
  input  lrucmc_cell_cmd_t cmd,
  input  logic [ID_W-1:0]  newer,
  input  logic [ID_W-1:0]  id,
  output logic [ID_W-1:0]  entry,
  output logic             match
);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry <= id;
    end else if (cmd.shift) begin
      entry <= newer;
    end
  end

  assign match = (entry == id);

endmodule
